@@ sv/gii_pkg.sv @@
// Shared types, constants and the gray conversion for the gray integral image block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gii_pkg;

    localparam int CFG_W        = 11;
    localparam int PIX_W        = 24;
    localparam int SUM_W        = 31;
    localparam int GRAY_W       = 8;
    localparam int MAX_COLS_DEF = 1024;
    localparam int ROW_LIMIT    = 1024;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Register indexes of the configuration port.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Reciprocal of three in eleven fractional bits; exact for byte sums up to 765.
    localparam logic [9:0] GRAY_MUL = 10'd683;
    localparam int         GRAY_SH  = 11;

    typedef struct packed {
        logic              sel;
        logic              border;
        logic              row_end;
        logic              frame_end;
        logic [GRAY_W-1:0] gray;
    } t_item;

    function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] px);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b00, px[7:0]} + {2'b00, px[15:8]} + {2'b00, px[23:16]};
        p = {10'b0, s} * {10'b0, GRAY_MUL};
        return p[GRAY_SH +: GRAY_W];
    endfunction

endpackage

`default_nettype wire

@@ sv/gray_integral_image.sv @@
// Gray integral image: one grid slot per transfer, one summed-area result per slot.
// A transfer is queued in gii_fifo, then passes the back-end read stage and the output register.
// Throughput: one slot per cycle while the output is not stalled, set by the update in the back end.
// Reset is synchronous and active low: counters, queue and valid flags clear, both size
// registers return to 1024, and the sum store is left as it is with no clearing pass.
// Depends on gii_pkg, gii_front, gii_fifo and gii_back.
`default_nettype none

module gray_integral_image #(
    parameter int MAX_COLS = gii_pkg::MAX_COLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [gii_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [gii_pkg::PIX_W-1:0]     i_pixel_rgb,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [gii_pkg::SUM_W-1:0]          o_integral_sum,
    output logic                               o_row_end,
    output logic                               o_frame_end
);
    import gii_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS + 1);

    logic             push, pop, full, empty;
    t_item            front_item, head_item;
    logic [COL_W-1:0] front_col, head_col;

    gii_front #(.MAX_COLS(MAX_COLS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_pixel_rgb (i_pixel_rgb),
        .i_full      (full),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_item      (front_item),
        .o_col       (front_col)
    );

    gii_fifo #(.COL_W(COL_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_col   (front_col),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item),
        .o_col   (head_col)
    );

    gii_back #(.MAX_COLS(MAX_COLS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (head_item),
        .i_col          (head_col),
        .i_ready        (i_ready),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_integral_sum (o_integral_sum),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

endmodule

`default_nettype wire

@@ sv/gii_front.sv @@
// Front end: configuration registers, grid counters and per-slot classification.
// Depends on gii_pkg; feeds gii_fifo.
`default_nettype none

module gii_front #(
    parameter int MAX_COLS = gii_pkg::MAX_COLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [gii_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic [gii_pkg::PIX_W-1:0]          i_pixel_rgb,
    input  wire logic                               i_full,
    output logic                                    o_ready,
    output logic                                    o_push,
    output gii_pkg::t_item                          o_item,
    output logic [$clog2(MAX_COLS+1)-1:0]           o_col
);
    import gii_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] r_rows, r_cols;
    logic [CFG_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_sel, n_sel;
    logic [CFG_W-1:0] rows;
    logic [COL_W-1:0] cols;
    logic             rend, fend;

    always_comb begin
        if (r_rows == '0) begin
            rows = CFG_W'(1);
        end else if ({21'b0, r_rows} > 32'(ROW_LIMIT)) begin
            rows = CFG_W'(ROW_LIMIT);
        end else begin
            rows = r_rows;
        end
        if (r_cols == '0) begin
            cols = COL_W'(1);
        end else if ({21'b0, r_cols} > 32'(MAX_COLS)) begin
            cols = COL_W'(MAX_COLS);
        end else begin
            cols = COL_W'(r_cols);
        end
    end

    assign rend    = (r_col >= cols);
    assign fend    = rend && (r_row >= rows);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_col   = r_col;

    always_comb begin
        o_item.sel       = r_sel;
        o_item.border    = (r_row == '0) || (r_col == '0);
        o_item.row_end   = rend;
        o_item.frame_end = fend;
        o_item.gray      = gray_of(i_pixel_rgb);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_sel = r_sel;
        if (fend) begin
            n_row = '0;
            n_col = '0;
            n_sel = 1'b0;
        end else if (rend) begin
            n_row = r_row + CFG_W'(1);
            n_col = '0;
            n_sel = !r_sel;
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_RESET;
            r_cols <= CFG_RESET;
            r_row  <= '0;
            r_col  <= '0;
            r_sel  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default:  r_rows <= r_rows;
                endcase
            end
            if (o_push) begin
                r_row <= n_row;
                r_col <= n_col;
                r_sel <= n_sel;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/gii_fifo.sv @@
// Short queue of classified slots between the front and back ends.
// Depends on gii_pkg for the slot type and the queue depth.
`default_nettype none

module gii_fifo #(
    parameter int COL_W = $clog2(gii_pkg::MAX_COLS_DEF + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire gii_pkg::t_item    i_item,
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output gii_pkg::t_item         o_item,
    output logic [COL_W-1:0]       o_col
);
    import gii_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item            r_item [QUEUE_DEPTH];
    logic [COL_W-1:0] r_colq [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_item[r_rd];
    assign o_col   = r_colq[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item[r_wr] <= i_item;
            r_colq[r_wr] <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/gii_back.sv @@
// Back end: two-row sum store, running sum update and the output register.
// Depends on gii_pkg; takes slots from gii_fifo.
`default_nettype none

module gii_back #(
    parameter int MAX_COLS = gii_pkg::MAX_COLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_empty,
    input  wire gii_pkg::t_item                     i_item,
    input  wire logic [$clog2(MAX_COLS+1)-1:0]      i_col,
    input  wire logic                               i_ready,
    output logic                                    o_pop,
    output logic                                    o_valid,
    output logic [gii_pkg::SUM_W-1:0]               o_integral_sum,
    output logic                                    o_row_end,
    output logic                                    o_frame_end
);
    import gii_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int SLOTS = MAX_COLS + 1;
    localparam int MEM_D = 2 * SLOTS;
    localparam int AW    = $clog2(MEM_D);

    logic [SUM_W-1:0] mem [MEM_D];
    logic [SUM_W-1:0] r_rd_data;
    logic [SUM_W-1:0] r_prev_d, r_prev_above;
    logic             r_a_vld;
    t_item            r_a_item;
    logic [COL_W-1:0] r_a_col;
    logic             r_o_vld;
    logic [SUM_W-1:0] r_o_sum;
    logic             r_o_rend, r_o_fend;
    logic             a_adv;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [SUM_W-1:0] n_d;

    assign a_adv = r_a_vld && (!r_o_vld || i_ready);
    assign o_pop = !i_empty && (!r_a_vld || a_adv);

    // The current row writes its own half and reads the other one.
    assign rd_addr = i_item.sel ? AW'(i_col) : AW'(i_col) + AW'(SLOTS);
    assign wr_addr = r_a_item.sel ? AW'(r_a_col) + AW'(SLOTS) : AW'(r_a_col);

    always_comb begin
        if (r_a_item.border) begin
            n_d = '0;
        end else begin
            n_d = r_rd_data - r_prev_above + r_prev_d + SUM_W'(r_a_item.gray);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            mem[wr_addr] <= n_d;
        end
        if (o_pop) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_item <= i_item;
            r_a_col  <= i_col;
        end
        if (a_adv) begin
            r_prev_d     <= n_d;
            r_prev_above <= r_rd_data;
            r_o_sum      <= n_d;
            r_o_rend     <= r_a_item.row_end;
            r_o_fend     <= r_a_item.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (a_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_vld;
    assign o_integral_sum = r_o_sum;
    assign o_row_end      = r_o_rend;
    assign o_frame_end    = r_o_fend;

endmodule

`default_nettype wire

@@ sv/gii_checker.sv @@
// Port-level checks for gray_integral_image, attached to the top level by a bind.
// Depends on gii_pkg for the sum width.
`default_nettype none

module gii_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [gii_pkg::SUM_W-1:0] o_integral_sum,
    input wire logic                      o_row_end,
    input wire logic                      o_frame_end
);
    import gii_pkg::*;

    // The last slot of the grid is always the last slot of a row.
    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn before transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_integral_sum) && $stable(o_row_end)
            && $stable(o_frame_end))
        else $error("result changed while stalled");

endmodule

bind gray_integral_image gii_checker u_gii_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_integral_sum (o_integral_sum),
    .o_row_end      (o_row_end),
    .o_frame_end    (o_frame_end)
);

`default_nettype wire
